// ===== hw/rtl/lkv_pkg.sv =====
// lkv_pkg: shared types and constants for the LRU key-value cache.
// Used by lkv_cell and lru_key_value_cache; depends on nothing else.
package lkv_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] PUT_VALUE  = 32'h0000_0000;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// One slot of the recency chain.
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} entry_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic              update;  // cells at or below the limit take their neighbor
		logic              evict;   // cells past the limit drop their entry
		logic [DATA_W-1:0] key;     // key under lookup
	} ctl_t;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative key-value store, LRU replacement.
// An accepted request is registered, then looked up and the chain shifted in the exec
// state once the result register is free; no new request is taken until that is done.
// Lookup is a parallel key compare over the cell row; the row shifts one step.
// Reset (arst_n low, async): all slots empty, count zero, capacity 16.
// Depends on lkv_pkg and lkv_cell.
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] read_value,
	output logic               evicted,
	// capacity register
	input  logic               cfg_write,
	input  logic [4:0]         cfg_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CW    = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

	// control and request registers
	lkv_pkg::state_t            state_q, state_d;
	lkv_pkg::op_t               op_q;
	logic [lkv_pkg::DATA_W-1:0] key_q;
	logic [lkv_pkg::DATA_W-1:0] val_q;
	logic [lkv_pkg::CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]           occ_q;

	// result register
	logic                       out_valid_q;
	logic                       hit_q;
	logic [lkv_pkg::DATA_W-1:0] rdata_q;
	logic                       evicted_q;

	logic                       in_fire;
	logic                       exec_go;

	// cell row
	lkv_pkg::entry_t            cell_ent [ENTRIES];
	logic [ENTRIES-1:0]         match_vec;
	logic [ENTRIES-1:0]         valid_vec;
	lkv_pkg::ctl_t              ctl;
	logic [IDX_W-1:0]           limit;
	lkv_pkg::entry_t            new_ent;

	// lookup results
	logic                       hit_c;
	logic [IDX_W-1:0]           found_c;
	logic [lkv_pkg::DATA_W-1:0] hit_val_c;

	// capacity / eviction arithmetic
	logic [CW-1:0]              cap_w;
	logic [CW-1:0]              capm1_w;
	logic [CW-1:0]              occ_w;
	logic [CW-1:0]              pos_w;
	logic                       miss_put;
	logic                       evict_c;

	assign in_stall  = (state_q != lkv_pkg::ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign exec_go   = (state_q == lkv_pkg::ST_EXEC) && (!out_valid_q || !out_stall);

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rdata_q;
	assign evicted    = evicted_q;

	// State machine: take a transfer, then execute once the result slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lkv_pkg::ST_IDLE: begin
				if (in_fire) state_d = lkv_pkg::ST_EXEC;
			end
			lkv_pkg::ST_EXEC: begin
				if (exec_go) state_d = lkv_pkg::ST_IDLE;
			end
			default: state_d = lkv_pkg::ST_IDLE;
		endcase
	end

	// Request capture; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= lkv_pkg::op_t'(operation);
			key_q <= key;
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_write) begin
			capacity_q <= cfg_data;
		end
	end

	// Keys held in valid slots are unique, so the match vector is one-hot
	// or empty: plain OR reductions give the hit index and its value.
	always_comb begin
		hit_c     = 1'b0;
		found_c   = '0;
		hit_val_c = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			if (match_vec[j]) begin
				hit_c     = 1'b1;
				found_c   = found_c | IDX_W'(j);
				hit_val_c = hit_val_c | cell_ent[j].value;
			end
		end
	end

	// Effective capacity is clamped to 1 .. ENTRIES.
	always_comb begin
		cap_w = CW'(capacity_q);
		if (cap_w == '0) begin
			cap_w = CW'(1);
		end else if (cap_w > CW'(ENTRIES)) begin
			cap_w = CW'(ENTRIES);
		end
		capm1_w = cap_w - CW'(1);
		occ_w   = CW'(occ_q);
	end

	// A new key goes in at slot 0; if the row is at or past capacity the
	// insert point is pinned at capacity-1 and everything beyond is dropped.
	assign miss_put = (op_q == lkv_pkg::OP_PUT) && !hit_c;
	assign evict_c  = miss_put && (occ_w > capm1_w);
	assign pos_w    = evict_c ? capm1_w : occ_w;
	assign limit    = hit_c ? found_c : pos_w[IDX_W-1:0];

	assign ctl.update = exec_go && ((op_q == lkv_pkg::OP_PUT) || hit_c);
	assign ctl.evict  = evict_c;
	assign ctl.key    = key_q;

	// Entry fed into the head of the chain (most recent slot).
	assign new_ent.valid = 1'b1;
	assign new_ent.key   = key_q;
	assign new_ent.value = (op_q == lkv_pkg::OP_PUT) ? val_q : hit_val_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (exec_go && miss_put) begin
			occ_q <= CNT_W'(pos_w + CW'(1));
		end
	end

	// Result register: separates the two channels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			hit_q     <= hit_c;
			evicted_q <= evict_c;
			if (op_q == lkv_pkg::OP_PUT) begin
				rdata_q <= lkv_pkg::PUT_VALUE;
			end else if (hit_c) begin
				rdata_q <= hit_val_c;
			end else begin
				rdata_q <= lkv_pkg::MISS_VALUE;
			end
		end
	end

	// Cell row: slot 0 is most recent, each cell shifts from its left neighbor.
	for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
		lkv_pkg::entry_t left_ent;
		if (j == 0) begin : g_head
			assign left_ent = new_ent;
		end else begin : g_body
			assign left_ent = cell_ent[j-1];
		end

		lkv_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.limit  (limit),
			.left   (left_ent),
			.ent    (cell_ent[j]),
			.match  (match_vec[j])
		);

		assign valid_vec[j] = cell_ent[j].valid;
	end

`ifndef SYNTHESIS
	// Keys in the row stay unique.
	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkv_pkg::ST_EXEC) |-> $onehot0(match_vec))
		else $error("more than one slot matched the key");

	// Occupied count tracks the number of valid slots.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occ_q))
		else $error("occupied count differs from valid slots");

	// Valid slots form a prefix of the row.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
		else $error("valid slots are not contiguous from slot 0");

	// An eviction only comes from a put that missed.
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evicted_q) |-> !hit_q)
		else $error("eviction reported on a hit");

	// A result is valid in the cycle after the item executes.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> (out_valid_q && state_q == lkv_pkg::ST_IDLE))
		else $error("executed item produced no result");
`endif

endmodule

// ===== hw/rtl/lkv_cell.sv =====
// lkv_cell: one slot of the recency-ordered chain; compares its key and
// takes its left neighbor's entry on a shift. Depends on lkv_pkg.
module lkv_cell #(
	parameter int IDX_W    = 4,
	parameter int CELL_IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lkv_pkg::ctl_t        ctl,
	input  logic [IDX_W-1:0]     limit,
	input  lkv_pkg::entry_t      left,
	output lkv_pkg::entry_t      ent,
	output logic                 match
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                      valid_q;
	logic [lkv_pkg::DATA_W-1:0] key_q;
	logic [lkv_pkg::DATA_W-1:0] value_q;
	logic                      shift_en;
	logic                      drop_en;

	assign shift_en = ctl.update && (MY_IDX <= limit);
	assign drop_en  = ctl.update && ctl.evict && (MY_IDX > limit);
	assign match    = valid_q && (key_q == ctl.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= left.valid;
		end else if (drop_en) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q   <= left.key;
			value_q <= left.value;
		end
	end

	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.value = value_q;

endmodule

// ===== tb/sv/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
// lru_key_value_cache_tb: self-checking testbench for the LRU key-value cache.
// Holds a recency-ordered slot predictor in a small scoreboard class.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
module lru_key_value_cache_tb;

	localparam int SLOTS = 16;
	localparam int RANDOM_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int PRESSURE_AT = 300;     // results seen before the long hold-off
	localparam int PRESSURE_CYCLES = 120;
	localparam int MAX_REPORTS = 10;

	// One expected result, in the order of the result port fields.
	typedef struct packed {
		logic                       hit;
		logic [lkv_pkg::DATA_W-1:0] read_value;
		logic                       evicted;
	} lookup_result_t;

	// Scoreboard: mirrors the slot chain (slot 0 is most recent) and keeps the
	// results still owed by the block, oldest first.
	class lru_scoreboard;
		logic [lkv_pkg::DATA_W-1:0] keys[SLOTS];
		logic [lkv_pkg::DATA_W-1:0] values[SLOTS];
		bit                         live[SLOTS];
		int unsigned                occupancy;
		logic [lkv_pkg::CAP_W-1:0]  capacity;
		lookup_result_t             awaited[$];
		int errors, reported, requests, checked, hits, evictions, settings;

		function new();
			foreach (live[i]) begin
				live[i] = 1'b0;
			end
			occupancy = 0;
			capacity = lkv_pkg::CAP_RESET;
		endfunction

		function void set_capacity(logic [lkv_pkg::CAP_W-1:0] c);
			capacity = c;
			settings++;
		endfunction

		// Shift slots 0..pos-1 down one place and put the entry in front.
		function void move_front(int pos, logic [lkv_pkg::DATA_W-1:0] k,
			logic [lkv_pkg::DATA_W-1:0] v);
			for (int j = pos; j > 0; j--) begin
				keys[j] = keys[j-1];
				values[j] = values[j-1];
				live[j] = live[j-1];
			end
			keys[0] = k;
			values[0] = v;
			live[0] = 1'b1;
		endfunction

		function void note_request(lkv_pkg::op_t op, logic [lkv_pkg::DATA_W-1:0] k,
			logic [lkv_pkg::DATA_W-1:0] v);
			int found;
			int cap;
			int pos;
			lookup_result_t res;
			found = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (found < 0 && live[i] && keys[i] == k) begin
					found = i;
				end
			end
			res.hit = (found >= 0);
			res.read_value = lkv_pkg::PUT_VALUE;
			res.evicted = 1'b0;
			if (op == lkv_pkg::OP_GET) begin
				if (res.hit) begin
					res.read_value = values[found];
					move_front(found, k, values[found]);
				end else begin
					res.read_value = lkv_pkg::MISS_VALUE;
				end
			end else if (res.hit) begin
				move_front(found, k, v);
			end else begin
				// zero acts as one, anything past the built size saturates
				cap = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
				pos = occupancy;
				if (pos > cap - 1) begin
					// full, or capacity was lowered: keep only cap-1 most recent
					pos = cap - 1;
					res.evicted = 1'b1;
					for (int i = pos; i < SLOTS; i++) begin
						live[i] = 1'b0;
					end
				end
				move_front(pos, k, v);
				occupancy = pos + 1;
			end
			hits += res.hit;
			evictions += res.evicted;
			requests++;
			awaited.push_back(res);
		endfunction

		function void check_result(logic h, logic [lkv_pkg::DATA_W-1:0] rv, logic ev);
			lookup_result_t want;
			checked++;
			if (awaited.size() == 0) begin
				errors++;
				if (reported < MAX_REPORTS) begin
					reported++;
					$display("ERROR: result with nothing expected: %s%0b %s%h %s%0b",
						"hit=", h, "read_value=", rv, "evicted=", ev);
				end
				return;
			end
			want = awaited.pop_front();
			if (h !== want.hit || rv !== want.read_value || ev !== want.evicted) begin
				errors++;
				if (reported < MAX_REPORTS) begin
					reported++;
					$display("ERROR: result %0d: expected hit=%0b read_value=%h evicted=%0b,",
						checked, want.hit, want.read_value, want.evicted);
					$display("       got hit=%0b read_value=%h evicted=%0b", h, rv, ev);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = 1'b0;
	logic signed [31:0] key = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic signed [31:0] read_value;
	logic               evicted;
	logic               cfg_write = 1'b0;
	logic [4:0]         cfg_data = '0;

	lru_scoreboard sb = new();

	// Percentage of cycles on which a gap or a stall may start; set per phase,
	// zero gives stretches with no idling at all.
	int idle_pct = 30;

	// Key pool for the random part: small enough that hits and evictions are common.
	logic [31:0] key_pool[$];

	always #1 clk = ~clk;

	lru_key_value_cache #(
		.ENTRIES(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data)
	);

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct) begin
			return 0;
		end
		if ($urandom_range(9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Offer one request and hold it until the transfer happens. Signals are sampled
	// right after the edge, so the values seen are those the block saw at the edge.
	task automatic send_request(lkv_pkg::op_t op, logic [31:0] k, logic [31:0] v);
		int gap;
		gap = pick_gap(idle_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		value <= v;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_request(op, k, v);
	endtask

	// Capacity changes only with the block idle: every owed result has arrived.
	task automatic write_capacity(logic [4:0] c);
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_capacity(c);
	endtask

	// Result side: checks each transfer and picks its own stall pattern. Once,
	// after PRESSURE_AT results, it holds off long enough for the block to back up.
	initial begin
		int stall_left;
		bit pressure_done;
		stall_left = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(hit, read_value, evicted);
			end
			if (!pressure_done && sb.checked >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				stall_left = PRESSURE_CYCLES;
			end
			if (stall_left == 0) begin
				stall_left = pick_gap(idle_pct);
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0) begin
				stall_left--;
			end
		end
	end

	// Generous fixed limit, far above the slowest legal run.
	initial begin
		#2000000;
		$display("lru_key_value_cache_tb: FAIL");
		$finish;
	end

	initial begin
		logic [4:0] phase_caps[RANDOM_PHASES];
		int pool_size;
		int eff_cap;
		logic [31:0] k;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes at reset capacity, hit, miss, update.
		send_request(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lkv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h1234_5678);
		send_request(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		// Capacity two with two entries held: a new key evicts the least recent.
		write_capacity(5'd2);
		send_request(lkv_pkg::OP_PUT, 32'h0000_0001, 32'h0000_0000);
		send_request(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(lkv_pkg::OP_PUT, 32'h0000_0002, 32'hA5A5_A5A5);
		send_request(lkv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
		// Capacity zero acts as one; an update of the only key must not evict.
		write_capacity(5'd0);
		send_request(lkv_pkg::OP_PUT, 32'h0000_0003, 32'h5A5A_5A5A);
		send_request(lkv_pkg::OP_PUT, 32'h0000_0003, 32'hFFFF_FFFF);
		send_request(lkv_pkg::OP_GET, 32'h0000_0003, 32'h0000_0000);
		// Above the built size saturates to full size.
		write_capacity(5'd31);
		send_request(lkv_pkg::OP_PUT, 32'h0000_0004, 32'h0000_0004);
		send_request(lkv_pkg::OP_PUT, 32'h0000_0005, 32'h8000_0000);
		send_request(lkv_pkg::OP_GET, 32'h0000_0003, 32'h0000_0000);
		send_request(lkv_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);

		// Random part: capacity steps down below the occupancy more than once,
		// so the multi-entry drop on a new key gets exercised.
		phase_caps = '{5'd16, 5'd3, 5'd31, 5'd8, 5'd1, 5'd17, 5'd12, 5'd0, 5'd2};
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_capacity(ph == RANDOM_PHASES - 1 ? 5'($urandom_range(31)) : phase_caps[ph]);
			eff_cap = (sb.capacity == 0) ? 1 :
				(sb.capacity > SLOTS) ? SLOTS : int'(sb.capacity);
			// phase 4 runs with no idling on either side
			idle_pct = (ph == 4) ? 0 : $urandom_range(10, 60);
			pool_size = eff_cap + 4;
			key_pool.delete();
			key_pool.push_back(32'h8000_0000);
			key_pool.push_back(32'h7FFF_FFFF);
			key_pool.push_back(32'h0000_0000);
			key_pool.push_back(32'hFFFF_FFFF);
			while (key_pool.size() < pool_size) key_pool.push_back($urandom);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 85) begin
					k = key_pool[$urandom_range(pool_size - 1)];
				end else begin
					k = $urandom;
				end
				send_request($urandom_range(1) ? lkv_pkg::OP_PUT : lkv_pkg::OP_GET,
					k, $urandom);
			end
		end

		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		// give a stray result time to show up
		repeat (8) @(posedge clk);

		$display("Covered %0d requests over %0d capacity writes: %0d hits, %0d evictions.",
			sb.requests, sb.settings, sb.hits, sb.evictions);
		$display("Checked %0d results, %0d mismatches, %0d still owed.",
			sb.checked, sb.errors, sb.awaited.size());
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("lru_key_value_cache_tb: PASS");
		end else begin
			$display("lru_key_value_cache_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== lru_key_value_cache.f =====
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_cell.sv
hw/rtl/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
